### rtl/abfa_pkg.sv
// shared types and constants of the aligned best-fit allocator
package abfa_pkg;

  localparam longint unsigned PAGE_BYTES_DEF = 64'd2097152;
  localparam int MAX_BLOCKS_DEF = 64;

  localparam int OFFSET_W = 21;
  localparam int SIZE_W = 22;
  localparam int ALIGN_W = 17;
  localparam int STAMP_W = 16;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic                  op;
    logic [OFFSET_W-1:0]   request_size;
    logic [ALIGN_W-1:0]    alignment;
    logic [OFFSET_W-1:0]   block_offset;
    logic [SIZE_W-1:0]     block_size;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [OFFSET_W-1:0]   granted_offset;
    logic [SIZE_W-1:0]     granted_size;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_NEED_GO,
    S_NEED_WAIT,
    S_RD,
    S_CHK,
    S_MOD_WAIT,
    S_COMMIT,
    S_TAIL
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,
    DP_DIV_NEED,
    DP_NEED,
    DP_READ,
    DP_DIV_ENTRY,
    DP_EVAL,
    DP_COMMIT,
    DP_TAIL
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic trivial;
    logic rd_valid;
    logic scan_last;
    logic div_busy;
    logic two_puts;
  } dp_stat_t;

endpackage

### rtl/abfa_div.sv
// bit-serial remainder unit, one dividend bit per cycle
module abfa_div #(
  parameter int AW = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [AW-1:0]                 dividend,
  input  logic [abfa_pkg::ALIGN_W-1:0]  divisor,
  output logic                          busy,
  output logic [abfa_pkg::ALIGN_W-1:0]  rem
);
  import abfa_pkg::*;

  localparam int CNT_W = $clog2(AW + 1);

  logic [CNT_W-1:0]   cnt;
  logic [AW-1:0]      shreg;
  logic [ALIGN_W-1:0] r;
  logic [ALIGN_W:0]   trial;

  assign busy  = (cnt != '0);
  assign rem   = r;
  assign trial = {r, shreg[AW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(AW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      r     <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, divisor}) begin
        r <= ALIGN_W'(trial - {1'b0, divisor});
      end else begin
        r <= trial[ALIGN_W-1:0];
      end
    end
  end

endmodule

### rtl/abfa_datapath.sv
// free table, candidate selection and commit logic
module abfa_datapath #(
  parameter longint unsigned PAGE_BYTES = abfa_pkg::PAGE_BYTES_DEF,
  parameter int              MAX_BLOCKS = abfa_pkg::MAX_BLOCKS_DEF,
  parameter int              AW         = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  abfa_pkg::dp_cmd_t   cmd,
  input  abfa_pkg::req_t      req,
  output abfa_pkg::dp_stat_t  stat,
  output abfa_pkg::rsp_t      rsp
);
  import abfa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [AW-1:0] PAGE_LEN = AW'(PAGE_BYTES);

  logic [AW-1:0]      mem_start [MAX_BLOCKS];
  logic [AW-1:0]      mem_len   [MAX_BLOCKS];
  logic [STAMP_W-1:0] mem_stamp [MAX_BLOCKS];

  logic [MAX_BLOCKS-1:0] valid;
  logic                  init0;
  logic [CW-1:0]         vcount;
  logic [STAMP_W-1:0]    next_stamp;

  logic                  op;
  logic [OFFSET_W-1:0]   size;
  logic [ALIGN_W-1:0]    align;
  logic [OFFSET_W-1:0]   boff;
  logic [SIZE_W-1:0]     bsize;
  logic [AW-1:0]         need;
  logic [IW-1:0]         idx;

  logic [AW-1:0]         rd_start;
  logic [AW-1:0]         rd_len;
  logic [STAMP_W-1:0]    rd_stamp;
  logic                  rd_valid;
  logic                  rd_init0;

  logic                  found;
  logic [IW-1:0]         best_idx;
  logic [AW-1:0]         best_start;
  logic [AW-1:0]         best_len;
  logic [AW-1:0]         best_gap;
  logic [STAMP_W-1:0]    best_age;

  logic                  pf;
  logic [IW-1:0]         prev_idx;
  logic [AW-1:0]         prev_start;
  logic [AW-1:0]         prev_len;
  logic                  nf;
  logic [IW-1:0]         next_idx;
  logic [AW-1:0]         next_start;
  logic [AW-1:0]         next_len;

  logic                  e0_ok;
  logic                  e1_ok;
  logic [IW-1:0]         e0;
  logic [IW-1:0]         e1;

  logic                  div_start;
  logic [AW-1:0]         div_dividend;
  logic                  div_busy;
  logic [ALIGN_W-1:0]    div_rem;

  logic [AW-1:0]         eff_start;
  logic [AW-1:0]         eff_len;
  logic [STAMP_W-1:0]    eff_age;
  logic [AW-1:0]         cand_gap;
  logic                  cand_fits;
  logic                  cand_better;
  logic                  trivial;
  logic [AW-1:0]         tail_len;
  logic [AW-1:0]         tail_start;
  logic [AW-1:0]         grant_off;
  logic [CW:0]           slots;
  logic                  mp;
  logic                  mn;
  logic [AW-1:0]         merge_start;
  logic [AW-1:0]         merge_len;
  logic [IW-1:0]         s1;
  logic [IW-1:0]         s2;
  logic [IW-1:0]         fslot;
  status_t               status;

  logic                  clr_a_en;
  logic [IW-1:0]         clr_a_idx;
  logic                  clr_b_en;
  logic [IW-1:0]         clr_b_idx;
  logic                  set_en;
  logic [IW-1:0]         set_idx;
  logic [AW-1:0]         wr_start;
  logic [AW-1:0]         wr_len;

  abfa_div #(.AW(AW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (align),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  assign div_start    = (cmd == DP_DIV_NEED) || (cmd == DP_DIV_ENTRY);
  assign div_dividend = (cmd == DP_DIV_NEED) ? AW'(size) : eff_start;

  assign eff_start = rd_init0 ? '0 : rd_start;
  assign eff_len   = rd_init0 ? PAGE_LEN : rd_len;
  assign eff_age   = next_stamp - (rd_init0 ? STAMP_W'(0) : rd_stamp);

  assign cand_gap    = (div_rem == '0) ? '0 : AW'(align - div_rem);
  assign cand_fits   = ({1'b0, cand_gap} + {1'b0, need}) <= {1'b0, eff_len};
  assign cand_better = !found || (eff_len < best_len) ||
                       ((eff_len == best_len) && (eff_age > best_age));

  assign trivial    = op ? (bsize == '0) : (size == '0);
  assign tail_len   = best_len - best_gap - need;
  assign tail_start = best_start + best_gap + need;
  assign grant_off  = best_start + best_gap;
  assign slots      = (CW+1)'(best_gap != '0) + (CW+1)'(tail_len != '0);

  assign mp = pf && (({1'b0, prev_start} + {1'b0, prev_len}) == (AW+1)'(boff));
  assign mn = nf && ((AW+1)'(boff) + (AW+1)'(bsize) == {1'b0, next_start});
  assign merge_start = mp ? prev_start : AW'(boff);
  assign merge_len   = AW'(bsize) + (mp ? prev_len : '0) + (mn ? next_len : '0);

  always_comb begin
    if (op == OP_ALLOC) begin
      if (trivial || !found) begin
        status = ST_NOFIT;
      end else if (({1'b0, vcount} + slots) > (CW+1)'(MAX_BLOCKS + 1)) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
      end
    end else begin
      if (!trivial && !mp && !mn && (vcount == CW'(MAX_BLOCKS))) begin
        status = ST_FULL;
      end else begin
        status = ST_OK;
      end
    end
  end

  // lowest free slots once the chosen or merged entries are released
  always_comb begin
    if (e0_ok && (e0 < best_idx)) begin
      s1 = e0;
      s2 = (e1_ok && (e1 < best_idx)) ? e1 : best_idx;
    end else begin
      s1 = best_idx;
      s2 = e0;
    end
    fslot = e0;
    if (mp && (!e0_ok || (prev_idx < fslot))) begin
      fslot = prev_idx;
    end
    if (mn && ((!e0_ok && !mp) || (next_idx < fslot))) begin
      fslot = next_idx;
    end
  end

  always_comb begin
    clr_a_en  = 1'b0;
    clr_a_idx = best_idx;
    clr_b_en  = 1'b0;
    clr_b_idx = next_idx;
    set_en    = 1'b0;
    set_idx   = s1;
    wr_start  = tail_start;
    wr_len    = tail_len;
    if ((cmd == DP_COMMIT) && (status == ST_OK) && !trivial) begin
      if (op == OP_ALLOC) begin
        clr_a_en = 1'b1;
        set_en   = (best_gap != '0) || (tail_len != '0);
        if (best_gap != '0) begin
          wr_start = best_start;
          wr_len   = best_gap;
        end
      end else begin
        clr_a_en  = mp;
        clr_a_idx = prev_idx;
        clr_b_en  = mn;
        set_en    = 1'b1;
        set_idx   = fslot;
        wr_start  = merge_start;
        wr_len    = merge_len;
      end
    end else if (cmd == DP_TAIL) begin
      set_en  = 1'b1;
      set_idx = s2;
    end
  end

  assign stat.is_free   = (op == OP_FREE);
  assign stat.trivial   = trivial;
  assign stat.rd_valid  = rd_valid;
  assign stat.scan_last = (idx == IW'(MAX_BLOCKS - 1));
  assign stat.div_busy  = div_busy;
  assign stat.two_puts  = (op == OP_ALLOC) && !trivial && (status == ST_OK) &&
                          (best_gap != '0) && (tail_len != '0);

  always_ff @(posedge clk) begin
    if (set_en) begin
      mem_start[set_idx] <= wr_start;
      mem_len[set_idx]   <= wr_len;
      mem_stamp[set_idx] <= next_stamp;
    end
    if (cmd == DP_READ) begin
      rd_start <= mem_start[idx];
      rd_len   <= mem_len[idx];
      rd_stamp <= mem_stamp[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= MAX_BLOCKS'(1);
      init0      <= 1'b1;
      vcount     <= CW'(1);
      next_stamp <= STAMP_W'(1);
      rd_valid   <= 1'b0;
      rd_init0   <= 1'b0;
    end else begin
      if (cmd == DP_READ) begin
        rd_valid <= valid[idx];
        rd_init0 <= init0 && (idx == '0);
      end
      begin
        logic [MAX_BLOCKS-1:0] vn;
        vn = valid;
        if (clr_a_en) vn[clr_a_idx] = 1'b0;
        if (clr_b_en) vn[clr_b_idx] = 1'b0;
        if (set_en)   vn[set_idx]   = 1'b1;
        valid <= vn;
      end
      vcount <= vcount - CW'(clr_a_en) - CW'(clr_b_en) + CW'(set_en);
      if (set_en) begin
        next_stamp <= next_stamp + 1'b1;
        if (set_idx == '0) begin
          init0 <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      pf    <= 1'b0;
      nf    <= 1'b0;
      e0_ok <= 1'b0;
      e1_ok <= 1'b0;
      idx   <= '0;
    end else if (cmd == DP_LOAD) begin
      found <= 1'b0;
      pf    <= 1'b0;
      nf    <= 1'b0;
      e0_ok <= 1'b0;
      e1_ok <= 1'b0;
      idx   <= '0;
    end else if (cmd == DP_EVAL) begin
      idx <= idx + 1'b1;
      if (!rd_valid) begin
        if (!e0_ok) begin
          e0_ok <= 1'b1;
        end else if (!e1_ok) begin
          e1_ok <= 1'b1;
        end
      end else if (op == OP_ALLOC) begin
        if (cand_fits && cand_better) begin
          found <= 1'b1;
        end
      end else if (eff_start <= AW'(boff)) begin
        if (!pf || (eff_start > prev_start)) begin
          pf <= 1'b1;
        end
      end else if (!nf || (eff_start < next_start)) begin
        nf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == DP_LOAD) begin
      op    <= req.op;
      size  <= req.request_size;
      align <= (req.alignment == '0) ? ALIGN_W'(1) : req.alignment;
      boff  <= req.block_offset;
      bsize <= req.block_size;
    end
    if (cmd == DP_NEED) begin
      need <= (div_rem == '0) ? AW'(size) : AW'(size) + AW'(align - div_rem);
    end
    if (cmd == DP_EVAL) begin
      if (!rd_valid) begin
        if (!e0_ok) begin
          e0 <= idx;
        end else if (!e1_ok) begin
          e1 <= idx;
        end
      end else if (op == OP_ALLOC) begin
        if (cand_fits && cand_better) begin
          best_idx   <= idx;
          best_start <= eff_start;
          best_len   <= eff_len;
          best_gap   <= cand_gap;
          best_age   <= eff_age;
        end
      end else if (eff_start <= AW'(boff)) begin
        if (!pf || (eff_start > prev_start)) begin
          prev_idx   <= idx;
          prev_start <= eff_start;
          prev_len   <= eff_len;
        end
      end else if (!nf || (eff_start < next_start)) begin
        next_idx   <= idx;
        next_start <= eff_start;
        next_len   <= eff_len;
      end
    end
    if (cmd == DP_COMMIT) begin
      rsp.status <= status;
      if ((op == OP_ALLOC) && (status == ST_OK)) begin
        rsp.granted_offset <= grant_off[OFFSET_W-1:0];
        rsp.granted_size   <= SIZE_W'(need);
      end else begin
        rsp.granted_offset <= '0;
        rsp.granted_size   <= '0;
      end
    end
  end

endmodule

### rtl/abfa_ctrl.sv
// sequencing state machine of the allocator
module abfa_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  input  abfa_pkg::dp_stat_t  stat,
  output abfa_pkg::dp_cmd_t   cmd
);
  import abfa_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == DP_COMMIT) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (req_valid) state_next = S_CHECK;
      S_CHECK: begin
        if (stat.trivial) begin
          state_next = S_COMMIT;
        end else if (stat.is_free) begin
          state_next = S_RD;
        end else begin
          state_next = S_NEED_GO;
        end
      end
      S_NEED_GO:   state_next = S_NEED_WAIT;
      S_NEED_WAIT: if (!stat.div_busy) state_next = S_RD;
      S_RD:        state_next = S_CHK;
      S_CHK: begin
        if (!stat.is_free && stat.rd_valid) begin
          state_next = S_MOD_WAIT;
        end else begin
          state_next = stat.scan_last ? S_COMMIT : S_RD;
        end
      end
      S_MOD_WAIT: begin
        if (!stat.div_busy) begin
          state_next = stat.scan_last ? S_COMMIT : S_RD;
        end
      end
      S_COMMIT: begin
        if (out_free) begin
          state_next = stat.two_puts ? S_TAIL : S_IDLE;
        end
      end
      S_TAIL:      state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = DP_NOP;
    req_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) cmd = DP_LOAD;
      end
      S_CHECK:     cmd = DP_NOP;
      S_NEED_GO:   cmd = DP_DIV_NEED;
      S_NEED_WAIT: if (!stat.div_busy) cmd = DP_NEED;
      S_RD:        cmd = DP_READ;
      S_CHK: begin
        if (!stat.is_free && stat.rd_valid) begin
          cmd = DP_DIV_ENTRY;
        end else begin
          cmd = DP_EVAL;
        end
      end
      S_MOD_WAIT:  if (!stat.div_busy) cmd = DP_EVAL;
      S_COMMIT:    if (out_free) cmd = DP_COMMIT;
      S_TAIL:      cmd = DP_TAIL;
      default:     cmd = DP_NOP;
    endcase
  end

endmodule

### rtl/aligned_best_fit_allocator.sv
// top level of the aligned best-fit page allocator
//
// usage: one request beat on req (valid/ready) asks to allocate or to free a
// range of the page; exactly one response beat on rsp (valid/ready) follows.
// req_ready is high only while the block waits for a request.
// an allocate first rounds the size with a bit-serial remainder unit
// (AW = log2(PAGE_BYTES) + 3), then reads every table entry through the
// single read port of the table and runs the same unit on each valid
// entry's start before the entry is evaluated.
// a free reads every entry once with no division.
// zero-size requests go straight to the commit without reading the table.
// an allocate that places both remnants writes the second one in a tail
// step after the response is loaded.
// reset leaves one free block covering the whole page and no response pending.
// the response sits in an output register; while the receiver stalls the
// next request is still taken and worked on, and only its own response waits.
module aligned_best_fit_allocator #(
  parameter longint unsigned PAGE_BYTES = abfa_pkg::PAGE_BYTES_DEF,
  parameter int              MAX_BLOCKS = abfa_pkg::MAX_BLOCKS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  abfa_pkg::req_t  req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output abfa_pkg::rsp_t  rsp
);
  import abfa_pkg::*;

  localparam int AW = $clog2(PAGE_BYTES) + 3;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  abfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  abfa_datapath #(
    .PAGE_BYTES (PAGE_BYTES),
    .MAX_BLOCKS (MAX_BLOCKS),
    .AW         (AW)
  ) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .stat (stat),
    .rsp  (rsp)
  );

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |-> (rsp.granted_offset == '0) &&
    (rsp.granted_size == '0))
    else $error("failed response carries a grant");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken while one is in work");

  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd == DP_COMMIT) |-> (!rsp_valid || rsp_ready))
    else $error("response overwritten before it was taken");
`endif

endmodule
